// ----- rtl/core/hac_pkg.sv -----
// ----------------------------------------------------------------------------
// hac_pkg
// Shared types and codes for the H-bridge actuator controller.
// ----------------------------------------------------------------------------
package hac_pkg;

  localparam int CH_W   = 3;   // channel field width
  localparam int DUR_W  = 32;  // timer / duration width
  localparam int CUR_W  = 16;  // signed current sample width
  localparam int REG_W  = 15;  // config register data width
  localparam int IDX_W  = 3;   // config register index width

  // item kinds
  localparam logic [1:0] FUNC_CMD    = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // channel modes
  localparam logic [1:0] MODE_STOP    = 2'd0;
  localparam logic [1:0] MODE_EXTEND  = 2'd1;
  localparam logic [1:0] MODE_RETRACT = 2'd2;
  localparam logic [1:0] MODE_FAULT   = 2'd3;

  // bridge pin patterns {pin two, pin one}
  localparam logic [1:0] PINS_OFF     = 2'b00;
  localparam logic [1:0] PINS_EXTEND  = 2'b01;
  localparam logic [1:0] PINS_RETRACT = 2'b10;

  // config register indexes
  localparam logic [IDX_W-1:0] REG_TRIP_LAST = 3'd6;  // trip limits are 0..6
  localparam logic [IDX_W-1:0] REG_END_TRAVEL = 3'd7;

  localparam logic [REG_W-1:0] TRIP_RESET = 15'h7FFF;
  localparam logic [REG_W-1:0] END_RESET  = 15'h0000;

  typedef struct packed {
    logic [1:0]       func;
    logic [CH_W-1:0]  channel;
    logic [1:0]       command_code;
    logic [DUR_W-1:0] duration_ms;
    logic [CUR_W-1:0] current_ma;
  } item_t;

  // per-channel state after the item being retired
  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] pins;
    logic       armed;
    logic       stopped;
  } chan_stat_t;

endpackage

// ----- rtl/core/hac_cfg.sv -----
// ----------------------------------------------------------------------------
// hac_cfg
// Trip limit and end-of-travel configuration registers.
// ----------------------------------------------------------------------------
module hac_cfg import hac_pkg::*; #(
  parameter int CHANNELS = 7
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [IDX_W-1:0]                wr_index,
  input  logic [REG_W-1:0]                wr_data,
  output logic [CHANNELS-1:0][REG_W-1:0]  trip_limit,
  output logic [REG_W-1:0]                end_travel
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < CHANNELS; n++) begin
        trip_limit[n] <= TRIP_RESET;
      end
      end_travel <= END_RESET;
    end else if (wr_en) begin
      // only seven trip registers exist; an eighth channel keeps its reset limit
      for (int n = 0; n < CHANNELS; n++) begin
        if (wr_index <= REG_TRIP_LAST && wr_index == IDX_W'(n)) begin
          trip_limit[n] <= wr_data;
        end
      end
      if (wr_index == REG_END_TRAVEL) begin
        end_travel <= wr_data;
      end
    end
  end

endmodule

// ----- rtl/core/hac_channel.sv -----
// ----------------------------------------------------------------------------
// hac_channel
// State and next-state logic of one actuator channel: mode, pins, stop timer.
// ----------------------------------------------------------------------------
module hac_channel import hac_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,        // item retires this cycle
  input  logic              sel,         // item addresses this channel
  input  item_t             item,
  input  logic [REG_W-1:0]  trip_limit,
  input  logic [REG_W-1:0]  end_travel,
  output chan_stat_t        stat_next
);

  logic [1:0]       mode;
  logic [1:0]       pins;
  logic             armed;
  logic [DUR_W-1:0] remaining;

  logic [1:0]       mode_next;
  logic [1:0]       pins_next;
  logic             armed_next;
  logic [DUR_W-1:0] remaining_next;
  logic             stopped;

  logic [DUR_W:0]   sum;
  logic             over_trip;
  logic             under_end;
  logic             moving;

  assign sum       = {1'b0, remaining} + {1'b0, item.duration_ms};
  assign over_trip = $signed(item.current_ma) > $signed({1'b0, trip_limit});
  assign under_end = $signed(item.current_ma) < $signed({1'b0, end_travel});
  assign moving    = (mode == MODE_EXTEND) || (mode == MODE_RETRACT);

  always_comb begin
    mode_next      = mode;
    pins_next      = pins;
    armed_next     = armed;
    remaining_next = remaining;
    stopped        = 1'b0;
    case (item.func)
      FUNC_CMD: begin
        if (sel) begin
          if (item.command_code[0]) begin
            mode_next = MODE_EXTEND;
            pins_next = PINS_EXTEND;
          end else begin
            mode_next = MODE_RETRACT;
            pins_next = PINS_RETRACT;
          end
          if (item.command_code[1]) begin
            if (armed) begin
              remaining_next = sum[DUR_W] ? '1 : sum[DUR_W-1:0];
            end else begin
              remaining_next = item.duration_ms;
            end
            armed_next = 1'b1;
          end
        end
      end
      FUNC_SAMPLE: begin
        if (sel) begin
          if (over_trip) begin
            mode_next      = MODE_FAULT;
            pins_next      = PINS_OFF;
            armed_next     = 1'b0;
            remaining_next = '0;
            stopped        = 1'b1;
          end else if (moving && under_end) begin
            mode_next      = MODE_STOP;
            pins_next      = PINS_OFF;
            armed_next     = 1'b0;
            remaining_next = '0;
            stopped        = 1'b1;
          end
        end
      end
      FUNC_TICK: begin
        if (armed) begin
          // expires at 0 or 1
          if (remaining[DUR_W-1:1] == '0) begin
            mode_next      = MODE_STOP;
            pins_next      = PINS_OFF;
            armed_next     = 1'b0;
            remaining_next = '0;
            stopped        = 1'b1;
          end else begin
            remaining_next = remaining - DUR_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_STOP;
      pins      <= PINS_OFF;
      armed     <= 1'b0;
      remaining <= '0;
    end else if (fire) begin
      mode      <= mode_next;
      pins      <= pins_next;
      armed     <= armed_next;
      remaining <= remaining_next;
    end
  end

  assign stat_next = '{mode: mode_next, pins: pins_next, armed: armed_next, stopped: stopped};

endmodule

// ----- rtl/core/hbridge_actuator_controller.sv -----
// ----------------------------------------------------------------------------
// hbridge_actuator_controller
// Multi-channel H-bridge actuator controller with stop timers and
// over-current / end-of-travel cutoff.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transaction: a
//   command, a current sample or a millisecond tick. Output channel
//   (out_valid / out_stall) returns exactly one result per item, in order.
//   Config channel (cfg_valid / cfg_ready) writes trip limits (index 0..6)
//   and the end-of-travel current (index 7); cfg_ready is always high.
//   Write config only while the block is empty.
// Timing:
//   Two register stages: an input register and a result register. out_valid
//   rises when the item moves from the input register into the result
//   register, which waits while out_stall holds a result there. Throughput
//   is one item per cycle while out_stall stays low; all channel state is
//   updated in the single cycle the item moves between the two registers.
// Stall:
//   While out_stall holds a result, the input register can still take one
//   more item; in_stall rises only when both stages are full.
// Reset:
//   rst (synchronous) empties both stages, stops all channels, drops all
//   pins, disarms all timers and restores the config reset values.
// ----------------------------------------------------------------------------
module hbridge_actuator_controller import hac_pkg::*; #(
  parameter int CHANNELS = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  // input items
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              func,
  input  logic [CH_W-1:0]         channel,
  input  logic [1:0]              command_code,
  input  logic [DUR_W-1:0]        duration_ms,
  input  logic [CUR_W-1:0]        current_ma,
  // results
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CH_W-1:0]         out_channel,
  output logic [1:0]              channel_mode,
  output logic [2*CHANNELS-1:0]   drive_pins,
  output logic [CHANNELS-1:0]     timers_armed,
  output logic                    stopped_now,
  // config writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [REG_W-1:0]        cfg_data
);

  // input register stage
  logic  s1_valid;
  item_t s1_item;

  logic  advance;   // result register free to load
  logic  fire;      // item retires into result register

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= '{func: func, channel: channel, command_code: command_code,
                   duration_ms: duration_ms, current_ma: current_ma};
    end
  end

  // config registers
  logic [CHANNELS-1:0][REG_W-1:0] trip_limit;
  logic [REG_W-1:0]               end_travel;

  assign cfg_ready = 1'b1;

  hac_cfg #(
    .CHANNELS (CHANNELS)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (cfg_valid),
    .wr_index   (cfg_index),
    .wr_data    (cfg_data),
    .trip_limit (trip_limit),
    .end_travel (end_travel)
  );

  // channel bank; an out-of-range channel field selects nothing
  chan_stat_t [CHANNELS-1:0] stat_next;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    hac_channel u_chan (
      .clk        (clk),
      .rst        (rst),
      .fire       (fire),
      .sel        (s1_item.channel == CH_W'(g)),
      .item       (s1_item),
      .trip_limit (trip_limit[g]),
      .end_travel (end_travel),
      .stat_next  (stat_next[g])
    );
  end

  // result assembly
  logic                  is_chan_item;
  logic [CH_W-1:0]       res_channel;
  logic [1:0]            res_mode;
  logic [2*CHANNELS-1:0] res_pins;
  logic [CHANNELS-1:0]   res_armed;
  logic                  res_stopped;

  assign is_chan_item = (s1_item.func == FUNC_CMD) || (s1_item.func == FUNC_SAMPLE);
  assign res_channel  = is_chan_item ? s1_item.channel : '0;

  always_comb begin
    res_mode    = MODE_STOP;
    res_stopped = 1'b0;
    for (int n = 0; n < CHANNELS; n++) begin
      res_pins[2*n +: 2] = stat_next[n].pins;
      res_armed[n]       = stat_next[n].armed;
      res_stopped        = res_stopped | stat_next[n].stopped;
      if (res_channel == CH_W'(n)) begin
        res_mode = stat_next[n].mode;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_channel  <= res_channel;
      channel_mode <= res_mode;
      drive_pins   <= res_pins;
      timers_armed <= res_armed;
      stopped_now  <= res_stopped;
    end
  end

  // checks
  logic [2*CHANNELS-1:0] pin_one_mask;
  logic                  pins_shorted;

  always_comb begin
    for (int n = 0; n < CHANNELS; n++) begin
      pin_one_mask[2*n +: 2] = 2'b01;
    end
  end

  assign pins_shorted = |(drive_pins & (drive_pins >> 1) & pin_one_mask);

  // a bridge never has both pins driven high
  a_no_shoot_through: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !pins_shorted)
    else $error("both pins of a bridge driven high");

  // an item leaving the input register shows up as a result next cycle
  a_retire_to_output: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("retired item missing from result register");

  // an out-of-range channel reports stopped mode and no stop
  a_bad_channel_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ({1'b0, out_channel} >= (CH_W+1)'(CHANNELS)))
      |-> (channel_mode == MODE_STOP && !stopped_now))
    else $error("out-of-range channel reported activity");

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the H-bridge actuator controller. A behavioral
// model of the seven channels predicts every result transaction; a monitor
// compares the DUT outputs field by field in order. Directed checks of drive,
// stop timers and current cutoff come first, then weighted random traffic
// under several trip / end-of-travel settings with random idling on both
// channels.
// ----------------------------------------------------------------------------
module tb_top import hac_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH         = 7;       // channels in the DUT build
  localparam int PIPE_DEPTH  = 2;       // input reg + result reg
  localparam int CYCLE_LIMIT = 400000;  // watchdog, far above a worst-case run
  localparam int PHASE_ITEMS = 250;     // random transactions per setting
  localparam int MAX_SHOWN   = 10;      // mismatches printed in full

  // one result transaction as seen on the output ports
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [1:0]       mode;
    logic [2*NCH-1:0] pins;
    logic [NCH-1:0]   armed;
    logic             stopped;
  } report_t;

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           func = FUNC_NONE;
  logic [CH_W-1:0]      channel = '0;
  logic [1:0]           command_code = '0;
  logic [DUR_W-1:0]     duration_ms = '0;
  logic [CUR_W-1:0]     current_ma = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CH_W-1:0]      out_channel;
  logic [1:0]           channel_mode;
  logic [2*NCH-1:0]     drive_pins;
  logic [NCH-1:0]       timers_armed;
  logic                 stopped_now;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  hbridge_actuator_controller #(.CHANNELS(NCH)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .channel      (channel),
    .command_code (command_code),
    .duration_ms  (duration_ms),
    .current_ma   (current_ma),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_channel  (out_channel),
    .channel_mode (channel_mode),
    .drive_pins   (drive_pins),
    .timers_armed (timers_armed),
    .stopped_now  (stopped_now),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Actuator model: shadow copy of channel state and config registers
  // --------------------------------------------------------------------------
  logic [1:0]       mode_q  [NCH];
  logic [1:0]       pins_q  [NCH];
  logic [DUR_W-1:0] tmr_q   [NCH];
  logic [NCH-1:0]   armed_q;
  logic [REG_W-1:0] trip_q  [NCH];
  logic [REG_W-1:0] end_travel_q;
  logic [REG_W-1:0] trip_plan [NCH];   // staged values for the next reload

  report_t expected_reports [$];

  int  mismatches  = 0;
  int  n_cmd       = 0;
  int  n_sample    = 0;
  int  n_tick      = 0;
  int  n_other     = 0;
  int  n_checked   = 0;
  int  n_cfg       = 0;
  int  n_stops     = 0;
  int  n_trips     = 0;
  int  cycle_cnt   = 0;
  int  stall_left  = 0;
  bit  calm        = 1'b1;   // no idling on either side while set

  function automatic void halt_channel(int n);
    pins_q[n]  = PINS_OFF;
    mode_q[n]  = MODE_STOP;
    armed_q[n] = 1'b0;
    tmr_q[n]   = '0;
  endfunction

  function automatic void reset_model();
    for (int n = 0; n < NCH; n++) begin
      halt_channel(n);
      trip_q[n] = TRIP_RESET;
    end
    end_travel_q = END_RESET;
  endfunction

  // Advance the model by one accepted input transaction.
  function automatic report_t predict_item(item_t it);
    report_t        r;
    int             ch;
    int             rch;
    int             cur;
    logic           hit;
    logic [DUR_W:0] sum;
    ch  = it.channel;
    rch = ch;
    cur = int'($signed(it.current_ma));
    hit = 1'b0;
    case (it.func)
      FUNC_CMD: begin
        n_cmd++;
        if (ch < NCH) begin
          // direction follows bit 0 of the code
          pins_q[ch] = it.command_code[0] ? PINS_EXTEND : PINS_RETRACT;
          mode_q[ch] = it.command_code[0] ? MODE_EXTEND : MODE_RETRACT;
          if (it.command_code[1]) begin
            if (armed_q[ch]) begin
              sum = {1'b0, tmr_q[ch]} + {1'b0, it.duration_ms};
              tmr_q[ch] = sum[DUR_W] ? {DUR_W{1'b1}} : sum[DUR_W-1:0];
            end else begin
              tmr_q[ch] = it.duration_ms;
            end
            armed_q[ch] = 1'b1;
          end
        end
      end
      FUNC_SAMPLE: begin
        n_sample++;
        if (ch < NCH) begin
          // trip check first, then end-of-travel on a still-moving channel
          if (cur > int'(trip_q[ch])) begin
            halt_channel(ch);
            mode_q[ch] = MODE_FAULT;
            hit = 1'b1;
            n_trips++;
          end
          if ((mode_q[ch] == MODE_EXTEND || mode_q[ch] == MODE_RETRACT) &&
              cur < int'(end_travel_q)) begin
            halt_channel(ch);
            hit = 1'b1;
          end
        end
      end
      FUNC_TICK: begin
        n_tick++;
        rch = 0;
        for (int n = 0; n < NCH; n++) begin
          if (armed_q[n]) begin
            if (tmr_q[n] <= 1) begin
              halt_channel(n);
              hit = 1'b1;
            end else begin
              tmr_q[n] = tmr_q[n] - 1;
            end
          end
        end
      end
      default: begin
        n_other++;
        rch = 0;
      end
    endcase
    if (hit) n_stops++;
    r.ch      = CH_W'(rch);
    r.mode    = (rch < NCH) ? mode_q[rch] : MODE_STOP;
    r.armed   = armed_q;
    r.stopped = hit;
    for (int n = 0; n < NCH; n++) r.pins[2*n +: 2] = pins_q[n];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Idle draw shared by sender and receiver: mostly short, sometimes long
  // --------------------------------------------------------------------------
  function automatic int draw_wait();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 8) return $urandom_range(1, 3);
    return $urandom_range(0, 15);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: one transaction per call, payload held while stalled
  // --------------------------------------------------------------------------
  task automatic send_item(input item_t it);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= it.func;
    channel      <= it.channel;
    command_code <= it.command_code;
    duration_ms  <= it.duration_ms;
    current_ma   <= it.current_ma;
    do @(posedge clk); while (in_stall);
    expected_reports.push_back(predict_item(it));
  endtask

  task automatic send_cmd(input int ch, input logic [1:0] code, input logic [DUR_W-1:0] dur);
    item_t it;
    it = '{func: FUNC_CMD, channel: CH_W'(ch), command_code: code,
           duration_ms: dur, current_ma: CUR_W'($urandom)};
    send_item(it);
  endtask

  task automatic send_sample(input int ch, input int cur);
    item_t it;
    it = '{func: FUNC_SAMPLE, channel: CH_W'(ch), command_code: 2'($urandom),
           duration_ms: $urandom, current_ma: CUR_W'(cur)};
    send_item(it);
  endtask

  task automatic send_tick();
    item_t it;
    it = '{func: FUNC_TICK, channel: CH_W'($urandom), command_code: 2'($urandom),
           duration_ms: $urandom, current_ma: CUR_W'($urandom)};
    send_item(it);
  endtask

  // Stop sending and let the pipeline empty out completely.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Write all eight registers from trip_plan and the given end-of-travel
  // level; only done with the block empty.
  task automatic load_regs(input logic [REG_W-1:0] end_lvl);
    logic [REG_W-1:0] data;
    wait_drained();
    for (int i = 0; i <= int'(REG_END_TRAVEL); i++) begin
      data = (i <= int'(REG_TRIP_LAST)) ? trip_plan[i] : end_lvl;
      cfg_valid <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data  <= data;
      do @(posedge clk); while (!cfg_ready);
      if (IDX_W'(i) <= REG_TRIP_LAST) trip_q[i] = data;
      else if (IDX_W'(i) == REG_END_TRAVEL) end_travel_q = data;
      n_cfg++;
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CUR_W-1:0] clamp_cur(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return CUR_W'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Random transaction: currents cluster around the active thresholds,
  // durations are mostly short so timers run out under the tick traffic.
  // --------------------------------------------------------------------------
  function automatic item_t random_item();
    item_t it;
    int    r;
    int    ch;
    int    lim;
    int    lo;
    it.func         = 2'($urandom);
    it.channel      = 3'($urandom);
    it.command_code = 2'($urandom);
    it.duration_ms  = $urandom;
    it.current_ma   = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 38)      it.func = FUNC_CMD;
    else if (r < 70) it.func = FUNC_SAMPLE;
    else if (r < 97) it.func = FUNC_TICK;
    else             it.func = FUNC_NONE;
    // out-of-range channel now and then
    it.channel = ($urandom_range(0, 19) == 0) ? CH_W'(NCH) : CH_W'($urandom_range(0, NCH-1));
    ch = it.channel;
    case ($urandom_range(0, 8))
      0, 1, 2, 3, 4, 5: it.duration_ms = $urandom_range(0, 12);
      6:                it.duration_ms = {DUR_W{1'b1}} - $urandom_range(0, 20);
      7:                it.duration_ms = $urandom;
      default:          it.duration_ms = $urandom_range(13, 60);
    endcase
    if (ch < NCH) begin
      lim = trip_q[ch];
      lo  = end_travel_q;
      case ($urandom_range(0, 7))
        0: it.current_ma = 16'($urandom);
        1: it.current_ma = clamp_cur(lim + $urandom_range(0, 3));
        2: it.current_ma = clamp_cur(lim - $urandom_range(0, 2));
        3: it.current_ma = clamp_cur(lo - 2 + $urandom_range(0, 3));
        4: begin
          case ($urandom_range(0, 3))
            0: it.current_ma = 16'h8000;
            1: it.current_ma = 16'h7FFF;
            2: it.current_ma = 16'h0000;
            default: it.current_ma = 16'hFFFF;
          endcase
        end
        default: begin
          if (lo <= lim) it.current_ma = CUR_W'($urandom_range(lo, lim));
          else           it.current_ma = 16'($urandom);
        end
      endcase
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Result monitor and receiver stall generator
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input report_t want, input report_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("[%0t] %s: exp ch=%0d mode=%0d pins=%h armed=%h stop=%0d",
               $realtime, what, want.ch, want.mode, want.pins, want.armed, want.stopped);
      $display("    got ch=%0d mode=%0d pins=%h armed=%h stop=%0d",
               got.ch, got.mode, got.pins, got.armed, got.stopped);
    end
  endtask

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_channel, channel_mode, drive_pins, timers_armed, stopped_now};
        if (expected_reports.size() == 0) begin
          flag_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_reports.pop_front();
          n_checked++;
          if (got.ch !== want.ch || got.mode !== want.mode || got.pins !== want.pins ||
              got.armed !== want.armed || got.stopped !== want.stopped)
            flag_mismatch("result mismatch", want, got);
        end
        stall_left = draw_wait();
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[%0t] watchdog expired, %0d results outstanding", $realtime,
             expected_reports.size());
    $display("hbridge_actuator_controller verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Drive directions, end-of-travel at reset levels, unused channel and func.
  task automatic test_drive_basics();
    send_cmd(0, 2'd1, 32'd0);                // extend
    send_cmd(NCH-1, 2'd0, 32'd0);            // retract, top channel
    send_sample(0, 32767);                   // at trip level: no trip
    send_sample(NCH-1, -32768);              // below end level 0: stop
    send_cmd(NCH, 2'd3, 32'hFFFF_FFFF);      // out of range: no effect
    send_sample(NCH, 32767);
    send_item('{func: FUNC_NONE, channel: 3'd5, command_code: 2'd3,
                duration_ms: 32'hFFFF_FFFF, current_ma: 16'h7FFF});
    send_tick();                             // nothing armed
  endtask

  // Zero duration, adding onto a running timer, saturation, plain commands
  // leaving the timer untouched.
  task automatic test_stop_timers();
    send_cmd(2, 2'd3, 32'd0);
    send_cmd(3, 2'd2, 32'd5);
    send_cmd(3, 2'd3, 32'hFFFF_FFFF);        // saturates
    send_cmd(4, 2'd2, 32'd2);
    send_cmd(4, 2'd1, 32'd999);              // timer kept at 2
    send_tick();                             // ch2 runs out
    send_tick();                             // ch4 runs out
    send_cmd(3, 2'd0, 32'd0);
  endtask

  // Trip on idle channel, command clearing a fault, end-of-travel cutoff,
  // zero trip level, negative current on an idle channel.
  task automatic test_current_cutoff();
    for (int n = 0; n < NCH; n++) trip_plan[n] = TRIP_RESET;
    trip_plan[5] = 15'd100;
    trip_plan[3] = 15'd0;
    load_regs(15'd50);
    send_sample(5, 101);                     // idle channel still faults
    send_cmd(5, 2'd0, 32'd0);                // command replaces fault
    send_sample(5, 100);                     // exactly at limit
    send_sample(5, 49);                      // under end level
    send_sample(3, 1);                       // trip at zero limit, disarms
    send_sample(1, -1);                      // idle: no end-of-travel stop
    send_cmd(1, 2'd3, 32'd1);
    send_tick();
  endtask

  // Weighted random traffic under several register settings.
  task automatic test_random_traffic();
    logic [REG_W-1:0] end_lvl;
    for (int phase = 0; phase < 5; phase++) begin
      for (int n = 0; n < NCH; n++) begin
        case (phase)
          0:       trip_plan[n] = TRIP_RESET;
          2:       trip_plan[n] = '0;
          3:       trip_plan[n] = ($urandom_range(0, 2) == 0) ? '0 :
                                  ($urandom_range(0, 1) ? TRIP_RESET : REG_W'($urandom));
          default: trip_plan[n] = REG_W'($urandom_range(200, 4000));
        endcase
      end
      case (phase)
        0:       end_lvl = END_RESET;
        2:       end_lvl = {REG_W{1'b1}};
        3:       end_lvl = REG_W'($urandom);
        default: end_lvl = REG_W'($urandom_range(0, 300));
      endcase
      load_regs(end_lvl);
      calm = (phase == 4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase != 4 && k % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        // hold the sender until the output side has caught up
        if (k == PHASE_ITEMS / 2) wait_drained();
        send_item(random_item());
      end
    end
    calm = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    calm = 1'b1;
    test_drive_basics();
    calm = 1'b0;
    test_stop_timers();
    test_current_cutoff();
    test_random_traffic();
    wait_drained();

    $display("Covered %0d transactions: %0d commands, %0d samples, %0d ticks, %0d unused",
             n_cmd + n_sample + n_tick + n_other, n_cmd, n_sample, n_tick, n_other);
    $display("%0d results checked, %0d register writes, %0d stop events, %0d trips",
             n_checked, n_cfg, n_stops, n_trips);
    if (mismatches == 0) begin
      $display("hbridge_actuator_controller verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("hbridge_actuator_controller verification failed");
    end
    $finish;
  end

endmodule

// ----- hbridge_actuator_controller.f -----
rtl/core/hac_pkg.sv
rtl/core/hac_cfg.sv
rtl/core/hac_channel.sv
rtl/core/hbridge_actuator_controller.sv
dv/tb_top.sv
